### hw/rtl/capb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capb_pkg: shared types and constants of the clipped alpha-over blender
// Field widths, register codes, reset values and the queue entry that links
// the front (clip, index, products) to the back (quotient pipeline).
// ----------------------------------------------------------------------------
package capb_pkg;

   // field widths
   localparam int CFG_W     = 13;
   localparam int COORD_W   = 14;
   localparam int CHAN_W    = 8;
   localparam int PROD8_W   = 2 * CHAN_W;
   localparam int INDEX_W   = 24;
   localparam int DEN_W     = 16;
   localparam int NUM_W     = 25;
   localparam int NUM_CHAN  = 3;
   localparam int CSR_IDX_W = 1;

   // defaults for top level parameters
   localparam int MAX_SURFACE_DIM_DEF = 4096;
   localparam int QUEUE_DEPTH_DEF     = 4;

   // register reset values
   localparam logic [CFG_W-1:0] SURFACE_WIDTH_RST  = 13'd1920;
   localparam logic [CFG_W-1:0] SURFACE_HEIGHT_RST = 13'd1080;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SURFACE_WIDTH  = 1'b0,
      REG_SURFACE_HEIGHT = 1'b1
   } csr_reg_type;

   // one pixel on its way from front to back
   typedef struct packed {
      logic                                write_enable;
      logic [INDEX_W-1:0]                  pixel_index;
      logic [CHAN_W-1:0]                   out_alpha;
      logic                                blank;
      logic [DEN_W-1:0]                    den;
      logic [NUM_CHAN-1:0][NUM_W-1:0]      num;
   } capb_entry_type;

endpackage
`default_nettype wire

### hw/rtl/capb_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capb_req_if: pixel request channel
// Valid/ready channel carrying the pixel position and both RGBA colors.
// ----------------------------------------------------------------------------
interface capb_req_if import capb_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic [CHAN_W-1:0]         src_red;
   logic [CHAN_W-1:0]         src_green;
   logic [CHAN_W-1:0]         src_blue;
   logic [CHAN_W-1:0]         src_alpha;
   logic [CHAN_W-1:0]         dst_red;
   logic [CHAN_W-1:0]         dst_green;
   logic [CHAN_W-1:0]         dst_blue;
   logic [CHAN_W-1:0]         dst_alpha;

   modport source (
      output valid, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
             dst_red, dst_green, dst_blue, dst_alpha,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, src_red, src_green, src_blue, src_alpha,
             dst_red, dst_green, dst_blue, dst_alpha,
      output ready
   );

endinterface
`default_nettype wire

### hw/rtl/capb_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capb_rsp_if: blended pixel result channel
// Valid/ready channel carrying the write flag, linear index and blended RGBA.
// ----------------------------------------------------------------------------
interface capb_rsp_if import capb_pkg::*; ();

   logic               valid;
   logic               ready;
   logic               write_enable;
   logic [INDEX_W-1:0] pixel_index;
   logic [CHAN_W-1:0]  out_red;
   logic [CHAN_W-1:0]  out_green;
   logic [CHAN_W-1:0]  out_blue;
   logic [CHAN_W-1:0]  out_alpha;

   modport source (
      output valid, write_enable, pixel_index, out_red, out_green, out_blue,
             out_alpha,
      input  ready
   );

   modport sink (
      input  valid, write_enable, pixel_index, out_red, out_green, out_blue,
             out_alpha,
      output ready
   );

endinterface
`default_nettype wire

### hw/rtl/capb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capb_front: surface registers, clipping and blend operand generation
// Two stages: stage A clips and forms the 8x8 products, stage B forms the
// pixel index, the blend numerators, the denominator and the output alpha,
// then pushes one entry into the queue.
// ----------------------------------------------------------------------------
module capb_front import capb_pkg::*; #(
   parameter int MAX_SURFACE_DIM = MAX_SURFACE_DIM_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   capb_req_if.sink                  req_bus,
   output logic                      push,
   output capb_entry_type            push_entry,
   input  wire logic                 queue_full
);

   localparam int DIM_W  = $clog2(MAX_SURFACE_DIM + 1);
   localparam int PROD_W = 2 * DIM_W;

   // exact floor(d / 255) for any d below 65280
   function automatic logic [CHAN_W-1:0] div255(input logic [DEN_W-1:0] d);
      logic [DEN_W:0] t;
      t = (DEN_W+1)'(d) + (DEN_W+1)'(d >> 8) + (DEN_W+1)'(1);
      return CHAN_W'(t >> 8);
   endfunction

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;

   logic [DIM_W-1:0]   w_eff;
   logic [DIM_W-1:0]   h_eff;
   logic               clip_in;
   logic [DIM_W-1:0]   col_in;
   logic [DIM_W-1:0]   row_in;
   logic [CHAN_W-1:0]  inv_in;
   logic [CHAN_W-1:0]  src_c [NUM_CHAN];
   logic [CHAN_W-1:0]  dst_c [NUM_CHAN];
   logic [PROD8_W-1:0] sp_in [NUM_CHAN];
   logic [PROD8_W-1:0] dp_in [NUM_CHAN];
   logic [PROD8_W-1:0] ad_inv_in;

   logic               va_ff;
   logic               a_clip_ff;
   logic [DIM_W-1:0]   a_col_ff;
   logic [DIM_W-1:0]   a_row_ff;
   logic [DIM_W-1:0]   a_w_ff;
   logic [CHAN_W-1:0]  a_as_ff;
   logic [CHAN_W-1:0]  a_inv_ff;
   logic [PROD8_W-1:0] a_ad_inv_ff;
   logic [PROD8_W-1:0] a_sp_ff [NUM_CHAN];
   logic [PROD8_W-1:0] a_dp_ff [NUM_CHAN];

   logic               vb_ff;
   capb_entry_type     b_entry_ff;
   capb_entry_type     b_entry_in;

   logic               advance;
   logic               accept;
   logic [PROD_W-1:0]  idx_sum;
   logic [DEN_W-1:0]   den_b;
   logic [NUM_W-2:0]   dmul [NUM_CHAN];

   // surface size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SURFACE_WIDTH_RST;
         height_ff <= SURFACE_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            REG_SURFACE_WIDTH:  width_ff  <= csr_wdata;
            REG_SURFACE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stall the whole front only when the queue cannot take stage B
   assign advance       = !(vb_ff && queue_full);
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;
   assign push          = vb_ff && !queue_full;
   assign push_entry    = b_entry_ff;

   assign src_c[0] = req_bus.src_red;
   assign src_c[1] = req_bus.src_green;
   assign src_c[2] = req_bus.src_blue;
   assign dst_c[0] = req_bus.dst_red;
   assign dst_c[1] = req_bus.dst_green;
   assign dst_c[2] = req_bus.dst_blue;

   // clamp dimensions, clip, flip row, form 8x8 products
   always_comb begin
      w_eff = (32'(width_ff) > 32'(MAX_SURFACE_DIM)) ?
              DIM_W'(MAX_SURFACE_DIM) : DIM_W'(width_ff);
      h_eff = (32'(height_ff) > 32'(MAX_SURFACE_DIM)) ?
              DIM_W'(MAX_SURFACE_DIM) : DIM_W'(height_ff);
      clip_in = req_bus.pos_x[COORD_W-1] || req_bus.pos_y[COORD_W-1] ||
                (32'(req_bus.pos_x[COORD_W-2:0]) >= 32'(w_eff)) ||
                (32'(req_bus.pos_y[COORD_W-2:0]) >= 32'(h_eff));
      col_in = DIM_W'(req_bus.pos_x[COORD_W-2:0]);
      row_in = h_eff - DIM_W'(1) - DIM_W'(req_bus.pos_y[COORD_W-2:0]);
      // invert at 8 bits before the product widens it
      inv_in    = ~req_bus.src_alpha;
      ad_inv_in = req_bus.dst_alpha * inv_in;
      for (int c = 0; c < NUM_CHAN; c++) begin
         sp_in[c] = src_c[c] * req_bus.src_alpha;
         dp_in[c] = dst_c[c] * req_bus.dst_alpha;
      end
   end

   // stage B: index, denominator, numerators, alpha
   always_comb begin
      idx_sum = PROD_W'(a_row_ff) * PROD_W'(a_w_ff) + PROD_W'(a_col_ff);
      den_b   = (DEN_W'(a_as_ff) << 8) - DEN_W'(a_as_ff) + a_ad_inv_ff;
      b_entry_in.write_enable = !a_clip_ff;
      b_entry_in.pixel_index  = a_clip_ff ? '0 : INDEX_W'(idx_sum);
      b_entry_in.out_alpha    = a_clip_ff ? '0 : div255(den_b);
      b_entry_in.blank        = a_clip_ff || (den_b == '0);
      b_entry_in.den          = den_b;
      for (int c = 0; c < NUM_CHAN; c++) begin
         dmul[c] = a_dp_ff[c] * a_inv_ff;
         b_entry_in.num[c] = (NUM_W'(a_sp_ff[c]) << 8) - NUM_W'(a_sp_ff[c]) +
                             NUM_W'(dmul[c]);
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= accept;
         vb_ff <= va_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         a_clip_ff   <= clip_in;
         a_col_ff    <= col_in;
         a_row_ff    <= row_in;
         a_w_ff      <= w_eff;
         a_as_ff     <= req_bus.src_alpha;
         a_inv_ff    <= inv_in;
         a_ad_inv_ff <= ad_inv_in;
         for (int c = 0; c < NUM_CHAN; c++) begin
            a_sp_ff[c] <= sp_in[c];
            a_dp_ff[c] <= dp_in[c];
         end
         b_entry_ff <= b_entry_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/capb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capb_queue: short FIFO between front and back
// Flip-flop entries, one write and one read per cycle, head shown directly.
// ----------------------------------------------------------------------------
module capb_queue import capb_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire capb_entry_type push_entry,
   output logic          full,
   input  wire logic     pop,
   output capb_entry_type head,
   output logic          empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   capb_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/capb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// capb_back: pipelined restoring divider and output register
// One quotient bit per stage for all three colors, most significant first,
// then an output register that zeroes colors of blank pixels.
// ----------------------------------------------------------------------------
module capb_back import capb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire capb_entry_type head,
   input  wire logic     empty,
   output logic          pop,
   capb_rsp_if.source    rsp_bus
);

   localparam int NSTG = CHAN_W;

   typedef struct packed {
      logic               write_enable;
      logic [INDEX_W-1:0] pixel_index;
      logic [CHAN_W-1:0]  out_alpha;
      logic               blank;
      logic [DEN_W-1:0]   den;
   } meta_type;

   logic                              v_ff    [NSTG];
   meta_type                          meta_ff [NSTG];
   logic [NUM_CHAN-1:0][NUM_W-1:0]    rem_ff  [NSTG];
   logic [NUM_CHAN-1:0][CHAN_W-1:0]   quo_ff  [NSTG];

   logic                              src_v    [NSTG];
   meta_type                          src_meta [NSTG];
   logic [NUM_CHAN-1:0][NUM_W-1:0]    src_rem  [NSTG];
   logic [NUM_CHAN-1:0][CHAN_W-1:0]   src_quo  [NSTG];
   logic [NUM_CHAN-1:0][NUM_W-1:0]    nx_rem   [NSTG];
   logic [NUM_CHAN-1:0][CHAN_W-1:0]   nx_quo   [NSTG];
   logic [NUM_W-1:0]                  trial    [NSTG];

   logic               out_v_ff;
   logic               out_we_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic [CHAN_W-1:0]  out_alpha_ff;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] out_color_ff;

   logic advance;

   // hold everything while a result waits
   assign advance = !(out_v_ff && !rsp_bus.ready);
   assign pop     = advance && !empty;

   // stage sources: queue head feeds the first stage
   always_comb begin
      src_v[0]              = !empty;
      src_meta[0].write_enable = head.write_enable;
      src_meta[0].pixel_index  = head.pixel_index;
      src_meta[0].out_alpha    = head.out_alpha;
      src_meta[0].blank        = head.blank;
      src_meta[0].den          = head.den;
      src_rem[0]            = head.num;
      src_quo[0]            = '0;
      for (int i = 1; i < NSTG; i++) begin
         src_v[i]    = v_ff[i-1];
         src_meta[i] = meta_ff[i-1];
         src_rem[i]  = rem_ff[i-1];
         src_quo[i]  = quo_ff[i-1];
      end
   end

   // one quotient bit per stage
   always_comb begin
      for (int i = 0; i < NSTG; i++) begin
         trial[i] = NUM_W'(src_meta[i].den) << (NSTG - 1 - i);
         for (int c = 0; c < NUM_CHAN; c++) begin
            if (src_rem[i][c] >= trial[i]) begin
               nx_rem[i][c] = src_rem[i][c] - trial[i];
               nx_quo[i][c] = {src_quo[i][c][CHAN_W-2:0], 1'b1};
            end else begin
               nx_rem[i][c] = src_rem[i][c];
               nx_quo[i][c] = {src_quo[i][c][CHAN_W-2:0], 1'b0};
            end
         end
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            v_ff[i] <= 1'b0;
         end
         out_v_ff <= 1'b0;
      end else if (advance) begin
         for (int i = 0; i < NSTG; i++) begin
            v_ff[i] <= src_v[i];
         end
         out_v_ff <= v_ff[NSTG-1];
      end
   end

   // advance payload, drop colors of blank pixels at the output
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NSTG; i++) begin
            meta_ff[i] <= src_meta[i];
            rem_ff[i]  <= nx_rem[i];
            quo_ff[i]  <= nx_quo[i];
         end
         out_we_ff    <= meta_ff[NSTG-1].write_enable;
         out_index_ff <= meta_ff[NSTG-1].pixel_index;
         out_alpha_ff <= meta_ff[NSTG-1].out_alpha;
         out_color_ff <= meta_ff[NSTG-1].blank ? '0 : quo_ff[NSTG-1];
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.write_enable = out_we_ff;
   assign rsp_bus.pixel_index  = out_index_ff;
   assign rsp_bus.out_alpha    = out_alpha_ff;
   assign rsp_bus.out_red      = out_color_ff[0];
   assign rsp_bus.out_green    = out_color_ff[1];
   assign rsp_bus.out_blue     = out_color_ff[2];

endmodule
`default_nettype wire

### hw/rtl/clipped_alpha_over_pixel_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clipped_alpha_over_pixel_blend: clipped source-over pixel blender
// Clips each pixel to the surface, gives its bottom-up linear index and
// blends source over destination with exact truncating integer division.
//
//   channel   | dir | handshake          | beat
//   ----------+-----+--------------------+-----------------------------------
//   req_bus   | in  | valid / ready      | position, source and dest RGBA
//   rsp_bus   | out | valid / ready      | write flag, index, blended RGBA
//   csr_*     | in  | csr_we             | surface width / height
//
// One beat per clock in and out while the result side is ready. A request
// passes 2 front stages, the queue, 8 divider stages (one quotient bit each)
// and the output register. Reset is synchronous and empties every stage and
// the queue. A stalled result stalls the divider; the front keeps taking
// requests until the queue fills.
// ----------------------------------------------------------------------------
module clipped_alpha_over_pixel_blend import capb_pkg::*; #(
   parameter int MAX_SURFACE_DIM = MAX_SURFACE_DIM_DEF,
   parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   capb_req_if.sink                  req_bus,
   capb_rsp_if.source                rsp_bus
);

   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;
   capb_entry_type q_push_entry;
   capb_entry_type q_head;

   capb_front #(
      .MAX_SURFACE_DIM (MAX_SURFACE_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_bus    (req_bus),
      .push       (q_push),
      .push_entry (q_push_entry),
      .queue_full (q_full)
   );

   capb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   capb_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (q_head),
      .empty   (q_empty),
      .pop     (q_pop),
      .rsp_bus (rsp_bus)
   );

   // clipped pixels come out all zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.write_enable |->
         rsp_bus.pixel_index == '0 && rsp_bus.out_alpha == '0 &&
         rsp_bus.out_red == '0 && rsp_bus.out_green == '0 && rsp_bus.out_blue == '0)
      else $error("clipped pixel carries nonzero fields");

   // zero output alpha means a zero denominator, so no color
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.out_alpha == '0 |->
         rsp_bus.out_red == '0 && rsp_bus.out_green == '0 && rsp_bus.out_blue == '0)
      else $error("color present with zero alpha");

   // queue never overflows or underflows
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

### sim/capb_blend_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capb_blend_checker: result checker for the clipped alpha-over blender
// Watches the register port and both channels. Each accepted pixel beat is
// clipped and blended here at the block's widths, and each result beat is
// compared field by field with the oldest blended pixel still due.
// ----------------------------------------------------------------------------
module capb_blend_checker import capb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   capb_req_if                       req_mon,
   capb_rsp_if                       rsp_mon,
   output int                        mismatch_count,
   output int                        pixels_in_flight
);

   typedef struct packed {
      logic [COORD_W-1:0]                 pos_x;
      logic [COORD_W-1:0]                 pos_y;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]    src_rgb;
      logic [CHAN_W-1:0]                  src_alpha;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]    dst_rgb;
      logic [CHAN_W-1:0]                  dst_alpha;
   } pixel_beat_type;

   typedef struct packed {
      logic                               write_enable;
      logic [INDEX_W-1:0]                 pixel_index;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]    out_rgb;
      logic [CHAN_W-1:0]                  out_alpha;
   } blended_pixel_type;

   logic [CFG_W-1:0]  width_reg;
   logic [CFG_W-1:0]  height_reg;
   blended_pixel_type blended_pixels_due[$];

   // Clip against the surface, flip the row and blend source over destination
   function automatic blended_pixel_type blend_pixel(pixel_beat_type p);
      blended_pixel_type r;
      int x, y, w, h, sa, da, inv, den, num, q;
      r = '0;
      w = (int'(width_reg) > MAX_SURFACE_DIM_DEF) ? MAX_SURFACE_DIM_DEF : int'(width_reg);
      h = (int'(height_reg) > MAX_SURFACE_DIM_DEF) ? MAX_SURFACE_DIM_DEF : int'(height_reg);
      x = $signed(p.pos_x);
      y = $signed(p.pos_y);
      if (x < 0 || y < 0 || x >= w || y >= h) begin
         return r;
      end
      r.write_enable = 1'b1;
      r.pixel_index  = INDEX_W'((h - 1 - y) * w + x);
      sa  = int'(p.src_alpha);
      da  = int'(p.dst_alpha);
      inv = 255 - sa;
      den = 255 * sa + da * inv;
      // both alphas clear: nothing to divide by, colors stay zero
      if (den == 0) begin
         return r;
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         num = int'(p.src_rgb[c]) * sa * 255 + int'(p.dst_rgb[c]) * da * inv;
         q   = num / den;
         r.out_rgb[c] = (q > 255) ? 8'd255 : CHAN_W'(q);
      end
      r.out_alpha = CHAN_W'(den / 255);
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   // Sample both channels and the register port on every rising edge
   always @(posedge clock) begin
      pixel_beat_type    beat;
      blended_pixel_type want;
      if (reset) begin
         blended_pixels_due.delete();
         width_reg      = SURFACE_WIDTH_RST;
         height_reg     = SURFACE_HEIGHT_RST;
         mismatch_count = 0;
      end else begin
         // compare the result beat with the oldest pixel due
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (blended_pixels_due.size() == 0) begin
               $error("result beat with no pixel outstanding");
               mismatch_count++;
            end else begin
               want = blended_pixels_due.pop_front();
               check_field("write_enable", want.write_enable, rsp_mon.write_enable);
               check_field("pixel_index", want.pixel_index, rsp_mon.pixel_index);
               check_field("out_red", want.out_rgb[0], rsp_mon.out_red);
               check_field("out_green", want.out_rgb[1], rsp_mon.out_green);
               check_field("out_blue", want.out_rgb[2], rsp_mon.out_blue);
               check_field("out_alpha", want.out_alpha, rsp_mon.out_alpha);
            end
         end
         // blend the accepted pixel beat with the current surface size
         if (req_mon.valid && req_mon.ready) begin
            beat.pos_x      = req_mon.pos_x;
            beat.pos_y      = req_mon.pos_y;
            beat.src_rgb[0] = req_mon.src_red;
            beat.src_rgb[1] = req_mon.src_green;
            beat.src_rgb[2] = req_mon.src_blue;
            beat.src_alpha  = req_mon.src_alpha;
            beat.dst_rgb[0] = req_mon.dst_red;
            beat.dst_rgb[1] = req_mon.dst_green;
            beat.dst_rgb[2] = req_mon.dst_blue;
            beat.dst_alpha  = req_mon.dst_alpha;
            blended_pixels_due.push_back(blend_pixel(beat));
         end
         // register writes apply to later beats
         if (csr_we) begin
            case (csr_reg_type'(csr_index))
               REG_SURFACE_WIDTH:  width_reg  = csr_wdata;
               REG_SURFACE_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end
      end
      pixels_in_flight = blended_pixels_due.size();
   end

endmodule

### sim/clipped_alpha_over_pixel_blend_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_alpha_over_pixel_blend_test: stimulus and verdict for the blender
// Draws directed corner, clipping and alpha cases on the reset surface, then
// random pixels over a series of surface sizes (zero, one, largest, above
// the largest). Both channel ends idle at random; one phase chokes the
// result side for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module clipped_alpha_over_pixel_blend_test;
   import capb_pkg::*;

   localparam int CHOKE_CYCLES = 100;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int SETTLE_CYCLES = 20;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   int                   mismatch_count;
   int                   pixels_in_flight;
   int                   eff_width;
   int                   eff_height;
   bit                   quiet_phase = 1'b0;
   bit                   choke_request = 1'b0;

   capb_req_if req_bus ();
   capb_rsp_if rsp_bus ();

   clipped_alpha_over_pixel_blend dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   capb_blend_checker blend_check (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .mismatch_count   (mismatch_count),
      .pixels_in_flight (pixels_in_flight)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short idle stretches, a few long ones, none in a quiet phase
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_phase || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Favor clear and opaque alphas
   function automatic logic [7:0] pick_alpha();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
         return 8'd0;
      end
      if (roll < 4) begin
         return 8'd255;
      end
      return 8'($urandom());
   endfunction

   // Offer one pixel beat, hold it until taken, then maybe idle
   task automatic send_pixel(input int x, input int y, input logic [31:0] src,
                             input logic [31:0] dst);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.pos_x     <= COORD_W'(x);
      req_bus.pos_y     <= COORD_W'(y);
      req_bus.src_red   <= src[31:24];
      req_bus.src_green <= src[23:16];
      req_bus.src_blue  <= src[15:8];
      req_bus.src_alpha <= src[7:0];
      req_bus.dst_red   <= dst[31:24];
      req_bus.dst_green <= dst[23:16];
      req_bus.dst_blue  <= dst[15:8];
      req_bus.dst_alpha <= dst[7:0];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Mostly inside the surface, some around its edges, some anywhere
   task automatic send_random_pixel();
      int x, y, roll;
      logic [31:0] src, dst;
      roll = $urandom_range(0, 99);
      if (roll < 70 && eff_width > 0 && eff_height > 0) begin
         x = $urandom_range(0, eff_width - 1);
         y = $urandom_range(0, eff_height - 1);
      end else if (roll < 85) begin
         x = int'($urandom_range(0, eff_width + 3)) - 2;
         y = int'($urandom_range(0, eff_height + 3)) - 2;
      end else begin
         x = int'($urandom_range(0, 16383)) - 8192;
         y = int'($urandom_range(0, 16383)) - 8192;
      end
      src = {24'($urandom_range(0, 16777215)), 8'h00} | 32'(pick_alpha());
      dst = {24'($urandom_range(0, 16777215)), 8'h00} | 32'(pick_alpha());
      send_pixel(x, y, src, dst);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Drain the block, then resize the surface
   task automatic set_surface(input logic [CFG_W-1:0] width,
                              input logic [CFG_W-1:0] height);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pixels_in_flight != 0) @(posedge clock);
      write_reg(REG_SURFACE_WIDTH, width);
      write_reg(REG_SURFACE_HEIGHT, height);
      eff_width  = (int'(width) > MAX_SURFACE_DIM_DEF) ? MAX_SURFACE_DIM_DEF : int'(width);
      eff_height = (int'(height) > MAX_SURFACE_DIM_DEF) ? MAX_SURFACE_DIM_DEF : int'(height);
   endtask

   // Result side: random stalls, one long choke on request
   initial begin
      int hold;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (choke_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (CHOKE_CYCLES) @(posedge clock);
            choke_request = 1'b0;
         end else begin
            hold = pick_gap();
            if (hold > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (hold) @(posedge clock);
            end else begin
               rsp_bus.ready <= 1'b1;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int waited;
      csr_we            <= 1'b0;
      csr_index         <= REG_SURFACE_WIDTH;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.pos_x     <= '0;
      req_bus.pos_y     <= '0;
      req_bus.src_red   <= '0;
      req_bus.src_green <= '0;
      req_bus.src_blue  <= '0;
      req_bus.src_alpha <= '0;
      req_bus.dst_red   <= '0;
      req_bus.dst_green <= '0;
      req_bus.dst_blue  <= '0;
      req_bus.dst_alpha <= '0;
      eff_width  = int'(SURFACE_WIDTH_RST);
      eff_height = int'(SURFACE_HEIGHT_RST);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // corners, clipping on every side, coordinate extremes, alpha corners
      send_pixel(0, 0, 32'hFF00_80FF, 32'h1234_56FF);
      send_pixel(1919, 1079, 32'h0000_0000, 32'hFFFF_FFFF);
      send_pixel(1919, 0, 32'h10C0_7F80, 32'h8080_8080);
      send_pixel(0, 1079, 32'hA5A5_A5C3, 32'h5A5A_5A3C);
      send_pixel(1920, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(0, 1080, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(-1, 500, 32'h8040_2080, 32'h1020_3040);
      send_pixel(700, -1, 32'h8040_2080, 32'h1020_3040);
      send_pixel(-1, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(1920, 1080, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(-8192, -8192, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(8191, 8191, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(8191, -8192, 32'h0102_0304, 32'h0506_0708);
      send_pixel(-8192, 8191, 32'h0102_0304, 32'h0506_0708);
      send_pixel(100, 200, 32'hFFFF_FF00, 32'hFFFF_FF00);
      send_pixel(101, 200, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(102, 200, 32'h0000_0000, 32'h0000_0000);
      send_pixel(103, 200, 32'hFF00_FF01, 32'h00FF_0001);
      send_pixel(104, 200, 32'hFFFF_FFFE, 32'h0000_00FF);
      send_pixel(105, 200, 32'h8040_2080, 32'hC0E0_F040);
      repeat (50) send_random_pixel();

      // single-pixel surface
      set_surface(13'd1, 13'd1);
      repeat (40) send_random_pixel();

      // largest surface, no idling on either side
      set_surface(13'd4096, 13'd4096);
      quiet_phase = 1'b1;
      repeat (50) send_random_pixel();
      quiet_phase = 1'b0;

      // register values above the largest surface clamp
      set_surface(13'd8191, 13'd8191);
      repeat (50) send_random_pixel();

      // zero width or height clips everything
      set_surface(13'd0, 13'd7);
      repeat (30) send_random_pixel();
      set_surface(13'd9, 13'd0);
      repeat (30) send_random_pixel();

      // choke the result side while pixels keep coming back to back
      set_surface(13'd5, 13'd3);
      quiet_phase   = 1'b1;
      choke_request = 1'b1;
      repeat (60) send_random_pixel();
      quiet_phase = 1'b0;

      // arbitrary register values
      set_surface(CFG_W'($urandom_range(1, 8191)), CFG_W'($urandom_range(1, 8191)));
      repeat (50) send_random_pixel();
      set_surface(13'd37, 13'd4095);
      repeat (50) send_random_pixel();

      // drain and settle
      req_bus.valid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (pixels_in_flight != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pixels_in_flight == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop if the run hangs
   initial begin
      #5000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
hw/rtl/capb_pkg.sv
hw/rtl/capb_req_if.sv
hw/rtl/capb_rsp_if.sv
hw/rtl/capb_front.sv
hw/rtl/capb_queue.sv
hw/rtl/capb_back.sv
hw/rtl/clipped_alpha_over_pixel_blend.sv
sim/capb_blend_checker.sv
sim/clipped_alpha_over_pixel_blend_test.sv
